// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the stencil top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/fds_pkg.sv
// Shared types, widths and the stencil coefficient tables.
package fds_pkg;

  localparam int LANES     = 7;
  localparam int SAMPLE_W  = 32;
  localparam int SCALE_W   = 32;
  localparam int COEF_W    = 36;
  localparam int COEF_FRAC = 30;
  localparam int OUT_FRAC  = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int SUM_W     = PROD_W + 4;
  localparam int ACC_W     = SUM_W - COEF_FRAC;
  localparam int PART_W    = ACC_W + SCALE_W / 2 + 1;
  localparam int FULL_W    = ACC_W + SCALE_W + 1;
  localparam int RES_W     = FULL_W - OUT_FRAC;

  localparam logic [2:0] PTS3 = 3'd3;
  localparam logic [2:0] PTS5 = 3'd5;
  localparam logic [2:0] PTS7 = 3'd7;

  localparam logic CFG_POINTS = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stn_ld_t;

  localparam longint Q1 = 64'sd1073741824;

  localparam longint K1_1     = (2 * 1 * Q1 + 1) / (2 * 1);
  localparam longint K2_1     = (2 * 2 * Q1 + 1) / (2 * 1);
  localparam longint K3_1     = (2 * 3 * Q1 + 1) / (2 * 1);
  localparam longint K4_1     = (2 * 4 * Q1 + 1) / (2 * 1);
  localparam longint K6_1     = (2 * 6 * Q1 + 1) / (2 * 1);
  localparam longint K1_2     = (2 * 1 * Q1 + 2) / (2 * 2);
  localparam longint K3_2     = (2 * 3 * Q1 + 2) / (2 * 2);
  localparam longint K5_2     = (2 * 5 * Q1 + 2) / (2 * 2);
  localparam longint K15_2    = (2 * 15 * Q1 + 2) / (2 * 2);
  localparam longint K19_2    = (2 * 19 * Q1 + 2) / (2 * 2);
  localparam longint K33_2    = (2 * 33 * Q1 + 2) / (2 * 2);
  localparam longint K1_3     = (2 * 1 * Q1 + 3) / (2 * 3);
  localparam longint K2_3     = (2 * 2 * Q1 + 3) / (2 * 3);
  localparam longint K4_3     = (2 * 4 * Q1 + 3) / (2 * 3);
  localparam longint K5_3     = (2 * 5 * Q1 + 3) / (2 * 3);
  localparam longint K7_3     = (2 * 7 * Q1 + 3) / (2 * 3);
  localparam longint K14_3    = (2 * 14 * Q1 + 3) / (2 * 3);
  localparam longint K20_3    = (2 * 20 * Q1 + 3) / (2 * 3);
  localparam longint K26_3    = (2 * 26 * Q1 + 3) / (2 * 3);
  localparam longint K1_4     = (2 * 1 * Q1 + 4) / (2 * 4);
  localparam longint K3_4     = (2 * 3 * Q1 + 4) / (2 * 4);
  localparam longint K15_4    = (2 * 15 * Q1 + 4) / (2 * 4);
  localparam longint K117_4   = (2 * 117 * Q1 + 4) / (2 * 4);
  localparam longint K2_5     = (2 * 2 * Q1 + 5) / (2 * 5);
  localparam longint K6_5     = (2 * 6 * Q1 + 5) / (2 * 5);
  localparam longint K27_5    = (2 * 27 * Q1 + 5) / (2 * 5);
  localparam longint K87_5    = (2 * 87 * Q1 + 5) / (2 * 5);
  localparam longint K1_6     = (2 * 1 * Q1 + 6) / (2 * 6);
  localparam longint K5_6     = (2 * 5 * Q1 + 6) / (2 * 6);
  localparam longint K10_9    = (2 * 10 * Q1 + 9) / (2 * 9);
  localparam longint K254_9   = (2 * 254 * Q1 + 9) / (2 * 9);
  localparam longint K1_12    = (2 * 1 * Q1 + 12) / (2 * 12);
  localparam longint K7_12    = (2 * 7 * Q1 + 12) / (2 * 12);
  localparam longint K11_12   = (2 * 11 * Q1 + 12) / (2 * 12);
  localparam longint K17_12   = (2 * 17 * Q1 + 12) / (2 * 12);
  localparam longint K19_12   = (2 * 19 * Q1 + 12) / (2 * 12);
  localparam longint K25_12   = (2 * 25 * Q1 + 12) / (2 * 12);
  localparam longint K35_12   = (2 * 35 * Q1 + 12) / (2 * 12);
  localparam longint K1_15    = (2 * 1 * Q1 + 15) / (2 * 15);
  localparam longint K2_15    = (2 * 2 * Q1 + 15) / (2 * 15);
  localparam longint K19_15   = (2 * 19 * Q1 + 15) / (2 * 15);
  localparam longint K47_18   = (2 * 47 * Q1 + 18) / (2 * 18);
  localparam longint K49_18   = (2 * 49 * Q1 + 18) / (2 * 18);
  localparam longint K3_20    = (2 * 3 * Q1 + 20) / (2 * 20);
  localparam longint K49_20   = (2 * 49 * Q1 + 20) / (2 * 20);
  localparam longint K1_30    = (2 * 1 * Q1 + 30) / (2 * 30);
  localparam longint K203_45  = (2 * 203 * Q1 + 45) / (2 * 45);
  localparam longint K1_60    = (2 * 1 * Q1 + 60) / (2 * 60);
  localparam longint K31_60   = (2 * 31 * Q1 + 60) / (2 * 60);
  localparam longint K49_60   = (2 * 49 * Q1 + 60) / (2 * 60);
  localparam longint K77_60   = (2 * 77 * Q1 + 60) / (2 * 60);
  localparam longint K1_90    = (2 * 1 * Q1 + 90) / (2 * 90);
  localparam longint K13_180  = (2 * 13 * Q1 + 180) / (2 * 180);
  localparam longint K137_180 = (2 * 137 * Q1 + 180) / (2 * 180);

  localparam longint W3 [2][3][3] = '{
    '{'{-K3_2, K2_1, -K1_2}, '{-K1_2, 0, K1_2}, '{K1_2, -K2_1, K3_2}},
    '{'{K1_1, -K2_1, K1_1}, '{K1_1, -K2_1, K1_1}, '{K1_1, -K2_1, K1_1}}};

  localparam longint W5 [2][5][5] = '{
    '{'{-K25_12, K4_1, -K3_1, K4_3, -K1_4},
      '{-K1_4, -K5_6, K3_2, -K1_2, K1_12},
      '{K1_12, -K2_3, 0, K2_3, -K1_12},
      '{-K1_12, K1_2, -K3_2, K5_6, K1_4},
      '{K1_4, -K4_3, K3_1, -K4_1, K25_12}},
    '{'{K35_12, -K26_3, K19_2, -K14_3, K11_12},
      '{K11_12, -K5_3, K1_2, K1_3, -K1_12},
      '{-K1_12, K4_3, -K5_2, K4_3, -K1_12},
      '{-K1_12, K1_3, K1_2, -K5_3, K11_12},
      '{K11_12, -K14_3, K19_2, -K26_3, K35_12}}};

  localparam longint W7 [2][7][7] = '{
    '{'{-K49_20, K6_1, -K15_2, K20_3, -K15_4, K6_5, -K1_6},
      '{-K1_6, -K77_60, K5_2, -K5_3, K5_6, -K1_4, K1_30},
      '{K1_30, -K2_5, -K7_12, K4_3, -K1_2, K2_15, -K1_60},
      '{-K1_60, K3_20, -K3_4, 0, K3_4, -K3_20, K1_60},
      '{K1_60, -K2_15, K1_2, -K4_3, K7_12, K2_5, -K1_30},
      '{-K1_30, K1_4, -K5_6, K5_3, -K5_2, K77_60, K1_6},
      '{K1_6, -K6_5, K15_4, -K20_3, K15_2, -K6_1, K49_20}},
    '{'{K203_45, -K87_5, K117_4, -K254_9, K33_2, -K27_5, K137_180},
      '{K137_180, -K49_60, -K17_12, K47_18, -K19_12, K31_60, -K13_180},
      '{-K13_180, K19_15, -K7_3, K10_9, K1_12, -K1_15, K1_90},
      '{K1_90, -K3_20, K3_2, -K49_18, K3_2, -K3_20, K1_90},
      '{K1_90, -K1_15, K1_12, K10_9, -K7_3, K19_15, -K13_180},
      '{-K13_180, K31_60, -K19_12, K47_18, -K17_12, -K49_60, K137_180},
      '{K137_180, -K27_5, K33_2, -K254_9, K117_4, -K87_5, K203_45}}};

  function automatic logic signed [COEF_W-1:0] stn_coef(input logic [2:0] pts,
                                                        input logic       ord,
                                                        input logic [2:0] off,
                                                        input logic [2:0] lane);
    longint c;
    c = 0;
    case (pts)
      PTS3: begin
        if (off < 3'd3 && lane < 3'd3) begin
          c = W3[ord][off[1:0]][lane[1:0]];
        end
      end
      PTS5: begin
        if (off < 3'd5 && lane < 3'd5) begin
          c = W5[ord][off][lane];
        end
      end
      PTS7: begin
        if (off < 3'd7 && lane < 3'd7) begin
          c = W7[ord][off][lane];
        end
      end
      default: c = 0;
    endcase
    return COEF_W'(c);
  endfunction

endpackage

// File: rtl/fds_lane.sv
// One stencil lane: registers a sample and its weight, then multiplies them.
module fds_lane import fds_pkg::*; (
  input  logic                       clk,
  input  stn_ld_t                    ld,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [COEF_W-1:0]   coef,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [COEF_W-1:0]   coef_r;
  logic signed [PROD_W-1:0]   prod_r;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      samp_r <= sample;
      coef_r <= coef;
    end
    if (ld.s2) begin
      prod_r <= samp_r * coef_r;
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/fds_merge.sv
// Merge stage: sums lane products, rounds, scales, rounds again and saturates; a bad stencil gives zero.
module fds_merge import fds_pkg::*; (
  input  logic                       clk,
  input  stn_ld_t                    ld,
  input  logic signed [PROD_W-1:0]   prod [LANES],
  input  logic [SCALE_W-1:0]         scale,
  input  logic                       bad,
  output logic signed [SAMPLE_W-1:0] derivative,
  output logic                       saturated,
  output logic                       bad_stencil
);

  localparam int HALF = SCALE_W / 2;
  localparam logic signed [SUM_W-1:0]  RND_ACC = SUM_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [FULL_W-1:0] RND_OUT = FULL_W'(1) <<< (OUT_FRAC - 1);

  logic signed [SUM_W-1:0]    psum_a_r, psum_b_r, psum_a_nxt, psum_b_nxt;
  logic [SCALE_W-1:0]         scale3_r, scale4_r;
  logic                       bad3_r, bad4_r, bad5_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [PART_W-1:0]   pl_r, ph_r, pl_nxt, ph_nxt;
  logic signed [SAMPLE_W-1:0] deriv_r, deriv_nxt;
  logic                       sat_r, sat_nxt, bad_r;

  always_comb begin
    psum_a_nxt = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    psum_b_nxt = SUM_W'(prod[4]) + SUM_W'(prod[5]) + SUM_W'(prod[6]);
  end

  always_comb begin
    logic signed [SUM_W-1:0] tot;
    tot     = psum_a_r + psum_b_r + RND_ACC;
    acc_nxt = ACC_W'(tot >>> COEF_FRAC);
  end

  always_comb begin
    pl_nxt = acc_r * $signed({1'b0, scale4_r[HALF-1:0]});
    ph_nxt = acc_r * $signed({1'b0, scale4_r[SCALE_W-1:HALF]});
  end

  always_comb begin
    logic signed [FULL_W-1:0] full;
    logic signed [RES_W-1:0]  res;
    logic [RES_W-SAMPLE_W:0]  hi;
    full = (FULL_W'(ph_r) <<< HALF) + FULL_W'(pl_r) + RND_OUT;
    res  = RES_W'(full >>> OUT_FRAC);
    hi   = res[RES_W-1:SAMPLE_W-1];
    deriv_nxt = res[SAMPLE_W-1:0];
    sat_nxt   = 1'b0;
    if (bad5_r) begin
      deriv_nxt = '0;
    end else if (!((&hi) || !(|hi))) begin
      sat_nxt   = 1'b1;
      deriv_nxt = res[RES_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      psum_a_r <= psum_a_nxt;
      psum_b_r <= psum_b_nxt;
      scale3_r <= scale;
      bad3_r   <= bad;
    end
    if (ld.s4) begin
      acc_r    <= acc_nxt;
      scale4_r <= scale3_r;
      bad4_r   <= bad3_r;
    end
    if (ld.s5) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      bad5_r <= bad4_r;
    end
    if (ld.s6) begin
      deriv_r <= deriv_nxt;
      sat_r   <= sat_nxt;
      bad_r   <= bad5_r;
    end
  end

  assign derivative  = deriv_r;
  assign saturated   = sat_r;
  assign bad_stencil = bad_r;

endmodule

// File: rtl/finite_difference_stencil_top.sv
// Finite-difference derivative stencil, top level with lanes and merge stage.
// Pipeline: six register stages; the first loads at the input accept edge and the
// sixth holds the result.
// Throughput: one item per cycle; stages hold only when the output is stalled.
// Reset: synchronous active low; empties the pipeline, points 3, offset 1.
`include "assert_macros.svh"

module finite_difference_stencil_top import fds_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [2:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_deriv_order,
  input  logic [SCALE_W-1:0]         in_inv_scale,
  input  logic signed [SAMPLE_W-1:0] in_sample_0,
  input  logic signed [SAMPLE_W-1:0] in_sample_1,
  input  logic signed [SAMPLE_W-1:0] in_sample_2,
  input  logic signed [SAMPLE_W-1:0] in_sample_3,
  input  logic signed [SAMPLE_W-1:0] in_sample_4,
  input  logic signed [SAMPLE_W-1:0] in_sample_5,
  input  logic signed [SAMPLE_W-1:0] in_sample_6,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_derivative,
  output logic                       out_bad_stencil,
  output logic                       out_saturated
);

  logic [2:0]                 pts_r, off_r;
  logic [5:0]                 v_r, v_nxt, rdy;
  stn_ld_t                    ld;
  logic                       bad_in;
  logic [SCALE_W-1:0]         scale1_r, scale2_r;
  logic                       bad1_r, bad2_r;
  logic signed [SAMPLE_W-1:0] samp [LANES];
  logic signed [COEF_W-1:0]   coef [LANES];
  logic signed [PROD_W-1:0]   prod [LANES];
  logic                       at_limit;

  assign samp[0] = in_sample_0;
  assign samp[1] = in_sample_1;
  assign samp[2] = in_sample_2;
  assign samp[3] = in_sample_3;
  assign samp[4] = in_sample_4;
  assign samp[5] = in_sample_5;
  assign samp[6] = in_sample_6;

  assign bad_in = !(pts_r == PTS3 || pts_r == PTS5 || pts_r == PTS7) || (off_r >= pts_r);

  always_comb begin
    rdy[5] = !v_r[5] || out_ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < 6; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
    ld.s1 = in_valid && rdy[0];
    ld.s2 = v_r[0] && rdy[1];
    ld.s3 = v_r[1] && rdy[2];
    ld.s4 = v_r[2] && rdy[3];
    ld.s5 = v_r[3] && rdy[4];
    ld.s6 = v_r[4] && rdy[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      pts_r <= PTS3;
      off_r <= 3'd1;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POINTS: pts_r <= cfg_data;
          CFG_OFFSET: off_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      scale1_r <= in_inv_scale;
      bad1_r   <= bad_in;
    end
    if (ld.s2) begin
      scale2_r <= scale1_r;
      bad2_r   <= bad1_r;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign coef[i] = stn_coef(pts_r, in_deriv_order, off_r, 3'(i));
    fds_lane u_lane (
      .clk    (clk),
      .ld     (ld),
      .sample (samp[i]),
      .coef   (coef[i]),
      .prod   (prod[i])
    );
  end

  fds_merge u_merge (
    .clk         (clk),
    .ld          (ld),
    .prod        (prod),
    .scale       (scale2_r),
    .bad         (bad2_r),
    .derivative  (out_derivative),
    .saturated   (out_saturated),
    .bad_stencil (out_bad_stencil)
  );

  assign in_ready  = rdy[0];
  assign out_valid = v_r[5];

  assign at_limit = out_derivative == 32'sh7fffffff || out_derivative == 32'sh80000000;

  `ASSERT_IMPL(a_bad_zero, out_valid && out_bad_stencil, out_derivative == '0 && !out_saturated)
  `ASSERT_IMPL(a_sat_bound, out_valid && out_saturated, at_limit)
  `ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v_r[0])
  `ASSERT_ALWAYS(a_ready_empty, v_r[0] || in_ready)

endmodule

// File: bench/tb_top.sv
// Testbench for the finite-difference stencil: directed and random windows against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import fds_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS   = 150;
  localparam int TAIL_CYCLES  = 20;
  localparam longint Q30      = 64'sd1073741824;

  // Weight rows as integer numerators over one denominator per size and order.
  localparam int DEN3 [2] = '{2, 1};
  localparam int DEN5 [2] = '{12, 12};
  localparam int DEN7 [2] = '{60, 180};

  localparam int NUM3 [2][3][3] = '{
    '{'{-3, 4, -1}, '{-1, 0, 1}, '{1, -4, 3}},
    '{'{1, -2, 1}, '{1, -2, 1}, '{1, -2, 1}}};

  localparam int NUM5 [2][5][5] = '{
    '{'{-25, 48, -36, 16, -3},
      '{-3, -10, 18, -6, 1},
      '{1, -8, 0, 8, -1},
      '{-1, 6, -18, 10, 3},
      '{3, -16, 36, -48, 25}},
    '{'{35, -104, 114, -56, 11},
      '{11, -20, 6, 4, -1},
      '{-1, 16, -30, 16, -1},
      '{-1, 4, 6, -20, 11},
      '{11, -56, 114, -104, 35}}};

  localparam int NUM7 [2][7][7] = '{
    '{'{-147, 360, -450, 400, -225, 72, -10},
      '{-10, -77, 150, -100, 50, -15, 2},
      '{2, -24, -35, 80, -30, 8, -1},
      '{-1, 9, -45, 0, 45, -9, 1},
      '{1, -8, 30, -80, 35, 24, -2},
      '{-2, 15, -50, 100, -150, 77, 10},
      '{10, -72, 225, -400, 450, -360, 147}},
    '{'{812, -3132, 5265, -5080, 2970, -972, 137},
      '{137, -147, -255, 470, -285, 93, -13},
      '{-13, 228, -420, 200, 15, -12, 2},
      '{2, -27, 270, -490, 270, -27, 2},
      '{2, -12, 15, 200, -420, 228, -13},
      '{-13, 93, -285, 470, -255, -147, 137},
      '{137, -972, 2970, -5080, 5265, -3132, 812}}};

  typedef struct {
    logic                       ord;
    logic [SCALE_W-1:0]         scale;
    logic signed [SAMPLE_W-1:0] smp [LANES];
  } window_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] deriv;
    logic                       bad;
    logic                       sat;
  } deriv_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [2:0]                 cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_deriv_order;
  logic [SCALE_W-1:0]         in_inv_scale;
  logic signed [SAMPLE_W-1:0] in_sample_0;
  logic signed [SAMPLE_W-1:0] in_sample_1;
  logic signed [SAMPLE_W-1:0] in_sample_2;
  logic signed [SAMPLE_W-1:0] in_sample_3;
  logic signed [SAMPLE_W-1:0] in_sample_4;
  logic signed [SAMPLE_W-1:0] in_sample_5;
  logic signed [SAMPLE_W-1:0] in_sample_6;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_derivative;
  logic                       out_bad_stencil;
  logic                       out_saturated;

  logic [2:0] points_reg;
  logic [2:0] offset_reg;
  deriv_t     pending_derivs [$];
  deriv_t     want;
  int         errors;
  int         cycle_count;
  bit         gaps_on;
  bit         stalls_on;

  finite_difference_stencil_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_deriv_order (in_deriv_order),
    .in_inv_scale   (in_inv_scale),
    .in_sample_0    (in_sample_0),
    .in_sample_1    (in_sample_1),
    .in_sample_2    (in_sample_2),
    .in_sample_3    (in_sample_3),
    .in_sample_4    (in_sample_4),
    .in_sample_5    (in_sample_5),
    .in_sample_6    (in_sample_6),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_derivative (out_derivative),
    .out_bad_stencil(out_bad_stencil),
    .out_saturated  (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint weight_q30(int pts, int ord, int off, int lane);
    int     num;
    int     den;
    longint mag;
    if (pts == PTS3) begin
      num = NUM3[ord][off][lane];
      den = DEN3[ord];
    end else if (pts == PTS5) begin
      num = NUM5[ord][off][lane];
      den = DEN5[ord];
    end else begin
      num = NUM7[ord][off][lane];
      den = DEN7[ord];
    end
    mag = (2 * longint'(num < 0 ? -num : num) * Q30 + den) / (2 * den);
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic deriv_t predict_derivative(window_t w, logic [2:0] pts, logic [2:0] off);
    deriv_t                r;
    logic signed [127:0]   total;
    logic signed [127:0]   smp_w;
    logic signed [127:0]   coef_w;
    logic signed [127:0]   scaled;
    r = '0;
    if (!(pts == PTS3 || pts == PTS5 || pts == PTS7) || off >= pts) begin
      r.bad = 1'b1;
      return r;
    end
    total = '0;
    for (int i = 0; i < int'(pts); i++) begin
      smp_w  = w.smp[i];
      coef_w = weight_q30(int'(pts), int'(w.ord), int'(off), i);
      total  = total + smp_w * coef_w;
    end
    total  = (total + (128'sd1 <<< 29)) >>> 30;
    scaled = total * $signed({96'd0, w.scale});
    scaled = (scaled + (128'sd1 <<< 15)) >>> 16;
    if (scaled > 128'sd2147483647) begin
      r.deriv = 32'h7fff_ffff;
      r.sat   = 1'b1;
    end else if (scaled < -128'sd2147483648) begin
      r.deriv = 32'h8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.deriv = scaled[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: v = $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic window_t rand_window();
    window_t     w;
    logic [31:0] base;
    bit          smooth;
    w.ord = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: w.scale = $urandom;
      3: w.scale = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: w.scale = $urandom_range(0, 32'h0004_0000);
    endcase
    base   = rand_sample();
    smooth = $urandom_range(0, 1);
    for (int i = 0; i < LANES; i++) begin
      w.smp[i] = smooth ? base + $urandom_range(0, 32'h0000_ffff) - 32'h0000_8000
                        : rand_sample();
    end
    return w;
  endfunction

  function automatic window_t make_window(logic ord, logic [31:0] scale,
                                          logic [31:0] even_v, logic [31:0] odd_v);
    window_t w;
    w.ord   = ord;
    w.scale = scale;
    for (int i = 0; i < LANES; i++) begin
      w.smp[i] = (i % 2 == 0) ? even_v : odd_v;
    end
    return w;
  endfunction

  task automatic send_window(input window_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_deriv_order <= w.ord;
    in_inv_scale   <= w.scale;
    in_sample_0    <= w.smp[0];
    in_sample_1    <= w.smp[1];
    in_sample_2    <= w.smp[2];
    in_sample_3    <= w.smp[3];
    in_sample_4    <= w.smp[4];
    in_sample_5    <= w.smp[5];
    in_sample_6    <= w.smp[6];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_derivs.push_back(predict_derivative(w, points_reg, offset_reg));
  endtask

  // Hold the input idle until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_derivs.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] pts, input logic [2:0] off);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POINTS;
    cfg_data  <= pts;
    @(posedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_data  <= off;
    @(posedge clk);
    cfg_we     <= 1'b0;
    points_reg = pts;
    offset_reg = off;
  endtask

  task automatic test_reset_defaults();
    send_window(make_window(1'b0, 32'h0001_0000, 32'h0, 32'h0));
    send_window(make_window(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000));
    send_window(make_window(1'b1, 32'h0002_0000, 32'hfffe_0000, 32'h0005_8000));
  endtask

  task automatic test_field_extremes();
    set_config(PTS7, 3'd0);
    send_window(make_window(1'b1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_window(make_window(1'b1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_window(make_window(1'b0, 32'h0, 32'h7fff_ffff, 32'h8000_0000));
    set_config(PTS5, 3'd4);
    send_window(make_window(1'b0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000));
    send_window(make_window(1'b1, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    set_config(PTS7, 3'd6);
    send_window(make_window(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001));
    send_window(make_window(1'b1, 32'hffff_ffff, 32'h0, 32'h0));
    set_config(PTS3, 3'd2);
    send_window(make_window(1'b1, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff));
    send_window(make_window(1'b0, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    set_config(PTS3, 3'd0);
    send_window(make_window(1'b0, 32'h8000_0000, 32'h0000_ffff, 32'hffff_0000));
  endtask

  task automatic test_bad_stencil();
    logic [2:0] bad_pts [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd6, 3'd3, 3'd5, 3'd7};
    logic [2:0] bad_off [8] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd5, 3'd3, 3'd5, 3'd7};
    for (int i = 0; i < 8; i++) begin
      set_config(bad_pts[i], bad_off[i]);
      send_window(rand_window());
    end
  endtask

  task automatic test_random_windows();
    int         sent;
    int         burst;
    logic [2:0] pts;
    logic [2:0] off;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0: pts = PTS3;
          1: pts = PTS5;
          default: pts = PTS7;
        endcase
        off = 3'($urandom_range(0, int'(pts) - 1));
      end else begin
        pts = 3'($urandom_range(0, 7));
        off = 3'($urandom_range(0, 7));
      end
      set_config(pts, off);
      gaps_on   = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      burst     = $urandom_range(10, 60);
      repeat (burst) begin
        send_window(rand_window());
        sent++;
        if ($urandom_range(0, 99) == 0) begin
          wait_drained();
        end
      end
    end
  endtask

  task automatic test_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_config(PTS7, 3'd3);
    repeat (CALM_ITEMS / 3) send_window(rand_window());
    set_config(PTS5, 3'd1);
    repeat (CALM_ITEMS / 3) send_window(rand_window());
    set_config(PTS3, 3'd1);
    repeat (CALM_ITEMS / 3) send_window(rand_window());
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_derivs.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: derivative %h bad_stencil %b saturated %b",
                 $time, out_derivative, out_bad_stencil, out_saturated);
      end else begin
        want = pending_derivs.pop_front();
        if (out_derivative !== want.deriv) begin
          errors++;
          $display("%0t: derivative expected %h actual %h", $time, want.deriv, out_derivative);
        end
        if (out_bad_stencil !== want.bad) begin
          errors++;
          $display("%0t: bad_stencil expected %b actual %b", $time, want.bad, out_bad_stencil);
        end
        if (out_saturated !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_saturated);
        end
      end
    end
  end

  initial begin
    errors         = 0;
    cycle_count    = 0;
    gaps_on        = 1'b0;
    stalls_on      = 1'b0;
    points_reg     = PTS3;
    offset_reg     = 3'd1;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_POINTS;
    cfg_data       <= 3'd0;
    in_valid       <= 1'b0;
    in_deriv_order <= 1'b0;
    in_inv_scale   <= '0;
    in_sample_0    <= '0;
    in_sample_1    <= '0;
    in_sample_2    <= '0;
    in_sample_3    <= '0;
    in_sample_4    <= '0;
    in_sample_5    <= '0;
    in_sample_6    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_bad_stencil();
    test_random_windows();
    test_no_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
